### hw/rtl/assert_macros.svh
// assertion helpers used by the top-level rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LSFE_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define LSFE_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/lsfe_pkg.sv
package lsfe_pkg;

   // spi bit codes
   localparam logic [7:0] CODE_HIGH_SHORT = 8'hF0;
   localparam logic [7:0] CODE_HIGH_LONG  = 8'hF8;
   localparam logic [7:0] CODE_LOW        = 8'hC0;
   localparam logic [7:0] MSB_MASK        = 8'h80;

   // pixel mode codes
   localparam logic [1:0] MODE_RAW   = 2'd0;
   localparam logic [1:0] MODE_SHORT = 2'd1;
   localparam logic [1:0] MODE_LONG  = 2'd2;

   // bytes per led
   localparam logic [4:0] BYTES_RAW      = 5'd3;
   localparam logic [4:0] BYTES_ONE_WIRE = 5'd24;

   // register indexes
   localparam int         CSR_INDEX_W    = 2;
   localparam int         CSR_DATA_W     = 12;
   localparam logic [1:0] CSR_STRIP_LEN  = 2'd0;
   localparam logic [1:0] CSR_PIXEL_MODE = 2'd1;

   // request codes
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_FETCH = 1'b1;

   typedef struct packed {
      logic clear_step;
      logic write_en;
      logic fetch_en;
      logic load_out;
   } lsfe_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } lsfe_status_type;

endpackage

### hw/rtl/lsfe_ctrl.sv
module lsfe_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_type,
   output logic                     req_stall,
   input  lsfe_pkg::lsfe_status_type status,
   output lsfe_pkg::lsfe_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_FETCH = 3'b100
   } lsfe_state_type;

   lsfe_state_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_stall      = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_type == lsfe_pkg::REQ_WRITE) begin
                  cmd.write_en = 1'b1;
               end else begin
                  cmd.fetch_en = 1'b1;
                  state_in     = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            // wait for the output register to free up
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/lsfe_datapath.sv
module lsfe_datapath #(
   parameter int MAX_LEDS = 2048
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lsfe_pkg::lsfe_cmd_type               cmd,
   output lsfe_pkg::lsfe_status_type            status,
   input  logic [10:0]                          req_led_index,
   input  logic [7:0]                           req_red,
   input  logic [7:0]                           req_green,
   input  logic [7:0]                           req_blue,
   input  logic                                 csr_valid,
   input  logic [lsfe_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lsfe_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic [7:0]                           rsp_spi_byte,
   output logic                                 rsp_frame_end
);

   localparam int AddrW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int CntW  = (AddrW + 1 > 12) ? AddrW + 1 : 12;
   localparam logic [CntW-1:0]  MaxCnt    = CntW'(MAX_LEDS);
   localparam logic [AddrW-1:0] LastAddr  = AddrW'(MAX_LEDS - 1);

   // configuration
   logic [11:0] strip_len_ff;
   logic [1:0]  pixel_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_len_ff  <= 12'd1;
         pixel_mode_ff <= lsfe_pkg::MODE_LONG;
      end else if (csr_valid) begin
         if (csr_index == lsfe_pkg::CSR_STRIP_LEN) begin
            strip_len_ff <= csr_wdata;
         end else if (csr_index == lsfe_pkg::CSR_PIXEL_MODE) begin
            pixel_mode_ff <= csr_wdata[1:0];
         end
      end
   end

   // effective count, zero taken as one, saturated at the store depth
   logic [CntW-1:0] count_raw, count_eff, count_m1;
   logic [4:0]      per_led, per_m1;

   always_comb begin
      count_raw = CntW'(strip_len_ff);
      if (count_raw == '0) begin
         count_raw = CntW'(1);
      end
      count_eff = (count_raw > MaxCnt) ? MaxCnt : count_raw;
      count_m1  = count_eff - CntW'(1);
      per_led   = (pixel_mode_ff == lsfe_pkg::MODE_RAW) ?
                  lsfe_pkg::BYTES_RAW : lsfe_pkg::BYTES_ONE_WIRE;
      per_m1    = per_led - 5'd1;
   end

   // clearing pass counter
   logic [AddrW-1:0] clear_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else if (cmd.clear_step) begin
         clear_addr_ff <= clear_addr_ff + AddrW'(1);
      end
   end

   // read position
   logic [AddrW-1:0] read_led_ff, read_led_in, cur_led;
   logic [4:0]       read_byte_ff, read_byte_in, cur_byte;
   logic             out_of_frame, is_last;

   always_comb begin
      out_of_frame = (CntW'(read_led_ff) >= count_eff) || (read_byte_ff >= per_led);
      cur_led      = out_of_frame ? '0 : read_led_ff;
      cur_byte     = out_of_frame ? 5'd0 : read_byte_ff;
      is_last      = (CntW'(cur_led) == count_m1) && (cur_byte == per_m1);
      if (is_last) begin
         read_led_in  = '0;
         read_byte_in = 5'd0;
      end else if (cur_byte == per_m1) begin
         read_led_in  = cur_led + AddrW'(1);
         read_byte_in = 5'd0;
      end else begin
         read_led_in  = cur_led;
         read_byte_in = cur_byte + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_led_ff  <= '0;
         read_byte_ff <= 5'd0;
      end else if (cmd.fetch_en) begin
         read_led_ff  <= read_led_in;
         read_byte_ff <= read_byte_in;
      end
   end

   // color store, red:green:blue
   logic [23:0]      mem [MAX_LEDS];
   logic [23:0]      rd_data_ff;
   logic [CntW-1:0]  wr_idx_ext;
   logic             wr_en;
   logic [AddrW-1:0] wr_addr;
   logic [23:0]      wr_data;

   always_comb begin
      wr_idx_ext = CntW'(req_led_index);
      if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = clear_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = cmd.write_en && (wr_idx_ext < count_eff);
         wr_addr = wr_idx_ext[AddrW-1:0];
         wr_data = {req_red, req_green, req_blue};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch_en) begin
         rd_data_ff <= mem[cur_led];
      end
   end

   // byte position of the fetch in flight
   logic [4:0] byte_sel_ff;
   logic       last_ff;

   always_ff @(posedge clock) begin
      if (cmd.fetch_en) begin
         byte_sel_ff <= cur_byte;
         last_ff     <= is_last;
      end
   end

   // encode
   logic [7:0] chan, enc_byte;

   always_comb begin
      unique case (byte_sel_ff[4:3])
         2'd0:    chan = rd_data_ff[15:8];
         2'd1:    chan = rd_data_ff[23:16];
         default: chan = rd_data_ff[7:0];
      endcase
      if (pixel_mode_ff == lsfe_pkg::MODE_RAW) begin
         unique case (byte_sel_ff)
            5'd0:    enc_byte = rd_data_ff[23:16];
            5'd1:    enc_byte = rd_data_ff[15:8];
            default: enc_byte = rd_data_ff[7:0];
         endcase
      end else if ((chan & (lsfe_pkg::MSB_MASK >> byte_sel_ff[2:0])) != 8'h00) begin
         enc_byte = (pixel_mode_ff == lsfe_pkg::MODE_SHORT) ?
                    lsfe_pkg::CODE_HIGH_SHORT : lsfe_pkg::CODE_HIGH_LONG;
      end else begin
         enc_byte = lsfe_pkg::CODE_LOW;
      end
   end

   // output register
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_byte_ff <= enc_byte;
         rsp_end_ff  <= last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_spi_byte      = rsp_byte_ff;
   assign rsp_frame_end     = rsp_end_ff;
   assign status.clear_last = (clear_addr_ff == LastAddr);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

endmodule

### hw/rtl/led_strip_frame_encoder.sv
// led strip frame encoder
// request channel (req_valid / req_stall): req_type selects a color write
// (req_led_index, req_red, req_green, req_blue) or a fetch of the next frame
// byte. a color write gives no response item; a write at or beyond the led
// count is dropped. a fetch gives one response item (rsp_spi_byte,
// rsp_frame_end); the store is read into a register when the fetch is
// accepted, and the output register loads from it once it is free, which
// sets rsp_valid. req_stall stays high after each fetch until that load,
// so the next request waits for it; writes run at one item per cycle while
// the block is idle.
// rsp_frame_end marks the last byte of a frame; the read position then wraps.
// csr channel (csr_valid / csr_ready): index 0 strip length, index 1 pixel
// mode; always ready, other indexes ignored. write it only while idle.
// reset: synchronous; after it the color store is swept to zero over all
// MAX_LEDS addresses; req_stall is high meanwhile (csr writes still taken).
// a stalled response is held in the output register; the next fetch is still
// accepted, but then req_stall stays high for writes and fetches alike until
// the held item has been taken
`include "assert_macros.svh"

module led_strip_frame_encoder #(
   parameter int MAX_LEDS = 2048
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_type,
   input  logic [10:0]                          req_led_index,
   input  logic [7:0]                           req_red,
   input  logic [7:0]                           req_green,
   input  logic [7:0]                           req_blue,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [7:0]                           rsp_spi_byte,
   output logic                                 rsp_frame_end,
   // register write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lsfe_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lsfe_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   lsfe_pkg::lsfe_cmd_type    cmd;
   lsfe_pkg::lsfe_status_type status;

   // registers are plain flops, a write never has to wait
   assign csr_ready = 1'b1;

   // sequencing: clear sweep, idle, fetch in flight
   lsfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // store, read position, encoder and output register
   lsfe_datapath #(
      .MAX_LEDS (MAX_LEDS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_led_index (req_led_index),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .csr_valid     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_spi_byte  (rsp_spi_byte),
      .rsp_frame_end (rsp_frame_end)
   );

   // no request taken while the store is being swept
   `LSFE_ASSERT_IMP(a_clear_blocks_req, clock, reset, cmd.clear_step, req_stall)
   // a fetch holds off the next item: req_stall is high in the cycle after it
   `LSFE_ASSERT_NXT(a_fetch_then_stall, clock, reset,
      req_valid && !req_stall && (req_type == lsfe_pkg::REQ_FETCH), req_stall)
   // a new response only comes from a load by the controller
   `LSFE_ASSERT_IMP(a_rsp_from_load, clock, reset, $rose(rsp_valid), $past(cmd.load_out))
   // a clear step never coincides with a store write, fetch or load
   `LSFE_ASSERT_IMP(a_cmd_exclusive, clock, reset, cmd.clear_step,
      !cmd.write_en && !cmd.fetch_en && !cmd.load_out)

endmodule

### bench/testbench.sv
module testbench;

   localparam int MAX_LEDS      = 2048;
   localparam int CYCLE_LIMIT   = 1000000;
   // settle time once every owed byte has come out
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS   = 10;
   // strip length for the full frame pass and items per random phase
   localparam int FRAME_LEDS    = 64;
   localparam int PHASE_ITEMS   = 85;

   // pixel mode code that the block treats as the long high code
   localparam logic [1:0] MODE_ALIAS_LONG = 2'd3;
   // register indexes that select nothing
   localparam logic [1:0] CSR_SPARE_A = 2'd2;
   localparam logic [1:0] CSR_SPARE_B = 2'd3;

   // one request item as it goes over the req channel
   typedef struct packed {
      logic        kind;
      logic [10:0] led_index;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } led_item_type;

   // one response item as it should come out of the rsp channel
   typedef struct packed {
      logic [7:0] spi;
      logic       frame_end;
   } spi_byte_type;

   // receiver back-pressure patterns
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   // shadow copy of the strip store and read position, plus the bytes still
   // owed by the block
   class strip_encoder_shadow;
      logic [23:0]  colors [MAX_LEDS];
      logic [11:0]  strip_len;
      logic [1:0]   pixel_mode;
      logic [10:0]  read_led;
      logic [4:0]   byte_pos;
      spi_byte_type owed_bytes [$];
      int unsigned  mismatches;
      int unsigned  writes_kept;
      int unsigned  writes_dropped;
      int unsigned  fetches;
      int unsigned  frame_ends;
      int unsigned  reg_writes;

      function new();
         foreach (colors[i]) colors[i] = '0;
         strip_len      = 12'd1;
         pixel_mode     = lsfe_pkg::MODE_LONG;
         read_led       = '0;
         byte_pos       = '0;
         mismatches     = 0;
         writes_kept    = 0;
         writes_dropped = 0;
         fetches        = 0;
         frame_ends     = 0;
         reg_writes     = 0;
      endfunction

      // zero means one led, anything past the store saturates
      function int unsigned strip_length();
         int unsigned n;
         n = 32'(strip_len);
         if (n == 0) n = 1;
         if (n > MAX_LEDS) n = MAX_LEDS;
         return n;
      endfunction

      function void write_reg(logic [1:0] index, logic [11:0] data);
         reg_writes++;
         if (index == lsfe_pkg::CSR_STRIP_LEN) strip_len = data;
         else if (index == lsfe_pkg::CSR_PIXEL_MODE) pixel_mode = data[1:0];
      endfunction

      function void note_item(led_item_type item);
         int unsigned  len;
         logic [4:0]   per;
         logic [23:0]  rgb;
         logic [7:0]   channel;
         spi_byte_type want;
         len = strip_length();
         if (item.kind == lsfe_pkg::REQ_WRITE) begin
            if (item.led_index < len) begin
               colors[item.led_index] = {item.red, item.green, item.blue};
               writes_kept++;
            end else begin
               writes_dropped++;
            end
            return;
         end
         per = (pixel_mode == lsfe_pkg::MODE_RAW) ?
               lsfe_pkg::BYTES_RAW : lsfe_pkg::BYTES_ONE_WIRE;
         // position left over from a larger frame restarts the frame
         if (read_led >= len || byte_pos >= per) begin
            read_led = '0;
            byte_pos = '0;
         end
         rgb = colors[read_led];
         if (pixel_mode == lsfe_pkg::MODE_RAW) begin
            case (byte_pos)
               5'd0:    want.spi = rgb[23:16];
               5'd1:    want.spi = rgb[15:8];
               default: want.spi = rgb[7:0];
            endcase
         end else begin
            // one-wire order is green, red, blue, msb first
            case (byte_pos[4:3])
               2'd0:    channel = rgb[15:8];
               2'd1:    channel = rgb[23:16];
               default: channel = rgb[7:0];
            endcase
            if ((channel & (lsfe_pkg::MSB_MASK >> byte_pos[2:0])) != 8'h00)
               want.spi = (pixel_mode == lsfe_pkg::MODE_SHORT) ?
                          lsfe_pkg::CODE_HIGH_SHORT : lsfe_pkg::CODE_HIGH_LONG;
            else
               want.spi = lsfe_pkg::CODE_LOW;
         end
         want.frame_end = (read_led == len - 1) && (byte_pos == per - 5'd1);
         owed_bytes.push_back(want);
         fetches++;
         if (want.frame_end) begin
            frame_ends++;
            read_led = '0;
            byte_pos = '0;
         end else if (byte_pos == per - 5'd1) begin
            byte_pos = '0;
            read_led++;
         end else begin
            byte_pos++;
         end
      endfunction

      function void check_byte(logic [7:0] spi, logic frame_end);
         spi_byte_type want;
         if (owed_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected byte %02h frame_end %0b at %0t", spi, frame_end, $realtime);
            return;
         end
         want = owed_bytes.pop_front();
         if (spi !== want.spi || frame_end !== want.frame_end) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("byte mismatch at %0t: expected %02h/%0b, got %02h/%0b",
                        $realtime, want.spi, want.frame_end, spi, frame_end);
         end
      endfunction

      function int unsigned outstanding();
         return owed_bytes.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_type;
   logic [10:0] req_led_index;
   logic [7:0]  req_red;
   logic [7:0]  req_green;
   logic [7:0]  req_blue;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_spi_byte;
   logic        rsp_frame_end;
   logic        csr_valid;
   logic        csr_ready;
   logic [lsfe_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [lsfe_pkg::CSR_DATA_W-1:0]  csr_wdata;

   strip_encoder_shadow shadow;
   int unsigned    cycle_count = 0;
   int unsigned    burst_left  = 0;
   int unsigned    settings    = 0;
   stall_mode_type stall_mode;
   int unsigned    stall_timer;

   led_strip_frame_encoder #(
      .MAX_LEDS(MAX_LEDS)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_led_index(req_led_index),
      .req_red      (req_red),
      .req_green    (req_green),
      .req_blue     (req_blue),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_spi_byte (rsp_spi_byte),
      .rsp_frame_end(rsp_frame_end),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case a handshake never completes
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // response side: check every item taken, then pick the next stall value.
   // the pattern is picked anew each time stall_timer runs out, so that quiet
   // stretches, light and heavy back-pressure and a strict toggle all show up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_mode  <= STALL_NONE;
         stall_timer <= 0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            shadow.check_byte(rsp_spi_byte, rsp_frame_end);
         if (stall_timer == 0) begin
            stall_mode  <= stall_mode_type'($urandom_range(0, 3));
            stall_timer <= $urandom_range(8, 80);
         end else begin
            stall_timer <= stall_timer - 1;
         end
         case (stall_mode)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 3) != 0);
            STALL_TOGGLE: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   // an item with every field random
   function automatic led_item_type random_item();
      led_item_type item;
      item.kind      = 1'($urandom);
      item.led_index = 11'($urandom);
      item.red       = 8'($urandom);
      item.green     = 8'($urandom);
      item.blue      = 8'($urandom);
      return item;
   endfunction

   // present one item and hold it until the block takes it. items come in
   // bursts; between bursts valid drops for a random number of cycles, and
   // some bursts follow each other with no gap at all
   task automatic send_item(input led_item_type item);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_type      <= item.kind;
      req_led_index <= item.led_index;
      req_red       <= item.red;
      req_green     <= item.green;
      req_blue      <= item.blue;
      do @(posedge clock); while (req_stall !== 1'b0);
      shadow.note_item(item);
   endtask

   task automatic write_led(input logic [10:0] index, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
      led_item_type item;
      item = {lsfe_pkg::REQ_WRITE, index, r, g, b};
      send_item(item);
   endtask

   // fetch items carry random junk in the color fields, which must not matter
   task automatic fetch_bytes(input int unsigned count);
      led_item_type item;
      repeat (count) begin
         item = random_item();
         item.kind = lsfe_pkg::REQ_FETCH;
         send_item(item);
      end
   endtask

   // valid stays high across back-to-back register writes; only the last drops it
   task automatic csr_write(input logic [1:0] index, input logic [11:0] data, input bit last);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      shadow.write_reg(index, data);
      if (last) csr_valid <= 1'b0;
   endtask

   // register writes only go in with the block idle. junk above the mode
   // bits must be dropped, and a write to a spare index must change nothing
   task automatic configure(input logic [11:0] count, input logic [1:0] led_kind,
                            input bit spare);
      settings++;
      csr_write(lsfe_pkg::CSR_STRIP_LEN, count, 1'b0);
      if (spare)
         csr_write($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, 12'($urandom), 1'b0);
      csr_write(lsfe_pkg::CSR_PIXEL_MODE, {10'($urandom), led_kind}, 1'b1);
   endtask

   // wait for every owed byte, then give a trailing color write time to land
   task automatic drain();
      req_valid <= 1'b0;
      while (shadow.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // random traffic under the current settings: mostly writes inside the
   // strip and fetches, some writes past its end and some anywhere at all
   task automatic random_phase(input int unsigned count);
      led_item_type item;
      int unsigned  len;
      len = shadow.strip_length();
      repeat (count) begin
         item = random_item();
         item.kind = ($urandom_range(0, 99) < 55) ? lsfe_pkg::REQ_FETCH : lsfe_pkg::REQ_WRITE;
         case ($urandom_range(0, 9))
            0: ;
            1: if (len < MAX_LEDS) item.led_index = 11'($urandom_range(MAX_LEDS - 1, len));
            default: item.led_index = 11'($urandom_range(len - 1, 0));
         endcase
         send_item(item);
      end
   endtask

   initial begin
      logic [11:0] count;
      logic [1:0]  led_kinds [4];
      shadow = new();
      led_kinds = '{lsfe_pkg::MODE_RAW, lsfe_pkg::MODE_SHORT, lsfe_pkg::MODE_LONG,
                    MODE_ALIAS_LONG};
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_type      <= lsfe_pkg::REQ_WRITE;
      req_led_index <= '0;
      req_red       <= '0;
      req_green     <= '0;
      req_blue      <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= lsfe_pkg::CSR_STRIP_LEN;
      csr_wdata     <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: one led, long high code. the store reads back as
      // zero, writes past the single led are dropped
      fetch_bytes(2);
      write_led(11'd0, 8'hFF, 8'h00, 8'hA5);
      write_led(11'd1, 8'h12, 8'h34, 8'h56);
      write_led(11'h7FF, 8'hFF, 8'hFF, 8'hFF);
      fetch_bytes(3);
      drain();

      // zero count acts as one led; raw mode finds the read position past
      // its three bytes and restarts the frame
      configure(12'd0, lsfe_pkg::MODE_RAW, 1'b1);
      fetch_bytes(4);
      drain();

      // count past the store saturates; mode three is the long high code
      configure(12'hFFF, MODE_ALIAS_LONG, 1'b0);
      write_led(11'h7FF, 8'h00, 8'hFF, 8'h00);
      fetch_bytes(2);
      drain();

      // short high code on a two-led strip, register writes leave the
      // read position where it was
      configure(12'd2, lsfe_pkg::MODE_SHORT, 1'b0);
      write_led(11'd1, 8'h80, 8'h01, 8'h7F);
      write_led(11'd2, 8'hAA, 8'h55, 8'hAA);
      fetch_bytes(6);
      drain();

      // one full frame in raw mode and a little past it, so the frame end
      // shows up on the very last led and the frame wraps
      configure(12'(FRAME_LEDS), lsfe_pkg::MODE_RAW, 1'b0);
      write_led(11'(FRAME_LEDS - 1), 8'($urandom), 8'($urandom), 8'($urandom));
      write_led(11'(FRAME_LEDS / 2), 8'($urandom), 8'($urandom), 8'($urandom));
      fetch_bytes(3 * FRAME_LEDS + 4);
      drain();

      // random settings, mostly short strips so frames wrap often
      repeat (16) begin
         case ($urandom_range(0, 9))
            0:       count = 12'd0;
            1:       count = 12'hFFF;
            2:       count = 12'(MAX_LEDS);
            3:       count = 12'($urandom);
            4, 5:    count = 12'($urandom_range(7, 40));
            default: count = 12'($urandom_range(1, 6));
         endcase
         configure(count, led_kinds[2'($urandom_range(0, 3))], $urandom_range(0, 3) == 0);
         random_phase(PHASE_ITEMS);
         drain();
      end

      $display("covered %0d color writes kept, %0d dropped, %0d fetched bytes, %0d frame ends",
               shadow.writes_kept, shadow.writes_dropped, shadow.fetches, shadow.frame_ends);
      $display("across %0d register settings (%0d register writes), %0d mismatches",
               settings, shadow.reg_writes, shadow.mismatches);
      if (shadow.outstanding() != 0)
         $display("%0d expected bytes never arrived", shadow.outstanding());
      if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/lsfe_pkg.sv
hw/rtl/lsfe_ctrl.sv
hw/rtl/lsfe_datapath.sv
hw/rtl/led_strip_frame_encoder.sv
bench/testbench.sv
